// ===== hdl/rtim_pkg.sv =====
package rtim_pkg;

   localparam int MODE_W   = 2;
   localparam int KEY_W    = 64;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 15;
   localparam int FANOUT   = 256;
   localparam int BYTE_W   = 8;
   localparam int FILL_W   = 9;

   localparam logic [MODE_W-1:0] MODE_GET     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OCCUPIED    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7fff;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    found_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

endpackage

// ===== hdl/rtim_req_if.sv =====
interface rtim_req_if;
   logic                       valid;
   logic                       ready;
   logic [rtim_pkg::MODE_W-1:0] mode;
   logic [rtim_pkg::KEY_W-1:0]  key;
   logic [rtim_pkg::VAL_W-1:0]  value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink (input valid, input mode, input key, input value, output ready);
endinterface

// ===== hdl/rtim_rsp_if.sv =====
interface rtim_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rtim_pkg::STATUS_W-1:0] status;
   logic [rtim_pkg::VAL_W-1:0]    found_value;
   logic [rtim_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output found_value, output entry_count,
                   input ready);
   modport sink (input valid, input status, input found_value, input entry_count,
                 output ready);
endinterface

// ===== hdl/rtim_engine.sv =====
module rtim_engine #(
   parameter int NODE_COUNT   = 64,
   parameter int INNER_LEVELS = 7,
   parameter int VALUE_BITS   = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rtim_pkg::req_type start_data,
   output logic              ready,
   output logic              done,
   output rtim_pkg::rsp_type result
);
   import rtim_pkg::*;

   localparam int NW    = $clog2(NODE_COUNT + 1);
   localparam int DW    = (VALUE_BITS > NW) ? VALUE_BITS : NW;
   localparam int AW    = NW + BYTE_W;
   localparam int DEPTH = (NODE_COUNT + 1) * FANOUT;
   localparam int LW    = $clog2(INNER_LEVELS + 1);
   localparam int FCW   = $clog2(NODE_COUNT + 1);
   localparam int FIW   = $clog2(NODE_COUNT);
   localparam int CW    = $clog2(NODE_COUNT * FANOUT + 1);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_WALK_RD  = 4'd2;
   localparam logic [3:0] S_WALK_EV  = 4'd3;
   localparam logic [3:0] S_DECIDE   = 4'd4;
   localparam logic [3:0] S_REM_SLOT = 4'd5;
   localparam logic [3:0] S_REM_FILL = 4'd6;
   localparam logic [3:0] S_ALLOC_RD = 4'd7;
   localparam logic [3:0] S_ALLOC_WR = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [LW-1:0]       lvl_ff, lvl_in;
   logic [NW-1:0]       path_ff [INNER_LEVELS+1];
   logic [NW-1:0]       path_in [INNER_LEVELS+1];
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [DW-1:0]       val_ff, val_in;
   logic [DW-1:0]       cur_ff, cur_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VAL_W-1:0]    found_ff, found_in;
   logic [FCW-1:0]      free_cnt_ff, free_cnt_in;
   logic [CW-1:0]       live_ff, live_in;

   logic [DW-1:0]     slot_mem [DEPTH];
   logic [FILL_W-1:0] fill_mem [NODE_COUNT+1];
   logic [FIW-1:0]    free_mem [NODE_COUNT];
   logic [DW-1:0]     slot_rd_ff;
   logic [FILL_W-1:0] fill_rd_ff;
   logic [FIW-1:0]    free_rd_ff;

   logic [AW-1:0]     slot_addr;
   logic              slot_we;
   logic [DW-1:0]     slot_wd;
   logic [NW-1:0]     fill_addr;
   logic              fill_we;
   logic [FILL_W-1:0] fill_wd;
   logic [FIW-1:0]    free_addr;
   logic              free_we;
   logic [FIW-1:0]    free_wd;

   logic [2:0]        bsel;
   logic [BYTE_W-1:0] kbyte;
   logic [AW-1:0]     walk_addr;
   logic              at_leaf;
   logic [LW-1:0]     need;
   logic [FCW-1:0]    fc_dec;
   logic [FILL_W-1:0] nf_dec;
   logic [63:0]       v64;
   logic [DW-1:0]     val_ext;
   logic              replace_wr;

   always_comb begin
      bsel      = 3'(INNER_LEVELS) - 3'(lvl_ff);
      kbyte     = key_ff[BYTE_W*bsel +: BYTE_W];
      walk_addr = {path_ff[lvl_ff], kbyte};
      at_leaf   = (lvl_ff == LW'(INNER_LEVELS));
      need      = LW'(INNER_LEVELS) - lvl_ff;
      fc_dec    = free_cnt_ff - 1'b1;
      nf_dec    = (fill_rd_ff != '0) ? fill_rd_ff - 1'b1 : '0;
      v64       = {32'b0, start_data.value};
      for (int i = 0; i < DW; i++) begin
         val_ext[i] = (i < VALUE_BITS) && v64[i];
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      lvl_in      = lvl_ff;
      path_in     = path_ff;
      mode_in     = mode_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      cur_in      = cur_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      free_cnt_in = free_cnt_ff;
      live_in     = live_ff;
      replace_wr  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in    = start_data.mode;
               key_in     = start_data.key;
               val_in     = val_ext;
               status_in  = ST_OK;
               found_in   = '0;
               lvl_in     = '0;
               path_in[0] = NW'(NODE_COUNT);
               state_in   = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_EV;
         end
         S_WALK_EV: begin
            if (at_leaf) begin
               cur_in   = slot_rd_ff;
               state_in = S_DECIDE;
            end else if (slot_rd_ff == '0 || slot_rd_ff > DW'(NODE_COUNT)) begin
               cur_in   = '0;
               state_in = S_DECIDE;
            end else begin
               path_in[LW'(lvl_ff + 1'b1)] = slot_rd_ff[NW-1:0] - 1'b1;
               lvl_in   = lvl_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (mode_ff)
               MODE_GET: begin
                  if ((&key_ff) || cur_ff == '0) begin
                     status_in = ST_NOT_PRESENT;
                  end else begin
                     found_in = VAL_W'(cur_ff);
                  end
               end
               MODE_REMOVE: begin
                  if (cur_ff == '0) begin
                     status_in = ST_NOT_PRESENT;
                  end else begin
                     state_in = S_REM_SLOT;
                  end
               end
               default: begin
                  if (cur_ff != '0) begin
                     if (mode_ff == MODE_ADD) begin
                        status_in = ST_OCCUPIED;
                     end else begin
                        found_in = VAL_W'(cur_ff);
                        if (val_ff != '0) begin
                           replace_wr = 1'b1;
                        end else begin
                           state_in = S_REM_SLOT;
                        end
                     end
                  end else if (val_ff != '0) begin
                     if (FCW'(need) > free_cnt_ff) begin
                        status_in = ST_EXHAUSTED;
                     end else begin
                        state_in = S_ALLOC_RD;
                     end
                  end
               end
            endcase
         end
         S_REM_SLOT: begin
            state_in = S_REM_FILL;
         end
         S_REM_FILL: begin
            if (at_leaf && live_ff != '0) begin
               live_in = live_ff - 1'b1;
            end
            if (lvl_ff != '0 && nf_dec == '0) begin
               if (free_cnt_ff < FCW'(NODE_COUNT)) begin
                  free_cnt_in = free_cnt_ff + 1'b1;
               end
               lvl_in   = lvl_ff - 1'b1;
               state_in = S_REM_SLOT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ALLOC_RD: begin
            state_in = S_ALLOC_WR;
         end
         S_ALLOC_WR: begin
            if (at_leaf) begin
               live_in  = live_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               path_in[LW'(lvl_ff + 1'b1)] = NW'(free_rd_ff);
               free_cnt_in = fc_dec;
               lvl_in      = lvl_ff + 1'b1;
               state_in    = S_ALLOC_RD;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memory port selection
   always_comb begin
      slot_addr = walk_addr;
      slot_we   = 1'b0;
      slot_wd   = '0;
      fill_addr = path_ff[lvl_ff];
      fill_we   = 1'b0;
      fill_wd   = '0;
      free_addr = fc_dec[FIW-1:0];
      free_we   = 1'b0;
      free_wd   = path_ff[lvl_ff][FIW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            slot_addr = clr_ff;
            slot_we   = 1'b1;
            fill_addr = clr_ff[NW-1:0];
            fill_we   = (clr_ff < AW'(NODE_COUNT + 1));
            free_addr = clr_ff[FIW-1:0];
            free_we   = (clr_ff < AW'(NODE_COUNT));
            free_wd   = FIW'(NODE_COUNT - 1) - clr_ff[FIW-1:0];
         end
         S_DECIDE: begin
            slot_we = replace_wr;
            slot_wd = val_ff;
         end
         S_REM_SLOT: begin
            slot_we = 1'b1;
         end
         S_REM_FILL: begin
            fill_we   = 1'b1;
            fill_wd   = nf_dec;
            free_addr = free_cnt_ff[FIW-1:0];
            free_we   = (lvl_ff != '0) && (nf_dec == '0) &&
                        (free_cnt_ff < FCW'(NODE_COUNT));
         end
         S_ALLOC_WR: begin
            slot_we = 1'b1;
            slot_wd = at_leaf ? val_ff : DW'(free_rd_ff) + 1'b1;
            fill_we = 1'b1;
            fill_wd = fill_rd_ff + 1'b1;
         end
         default: begin
            slot_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_addr] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_addr] <= fill_wd;
      end
      fill_rd_ff <= fill_mem[fill_addr];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_addr] <= free_wd;
      end
      free_rd_ff <= free_mem[free_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         free_cnt_ff <= FCW'(NODE_COUNT);
         live_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         free_cnt_ff <= free_cnt_in;
         live_ff     <= live_in;
      end
      lvl_ff    <= lvl_in;
      path_ff   <= path_in;
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   assign ready = (state_ff == S_IDLE);
   assign done  = (state_ff == S_DONE);

   always_comb begin
      result.status      = status_ff;
      result.found_value = found_ff;
      result.entry_count = (32'(live_ff) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(live_ff);
   end

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= FCW'(NODE_COUNT))
      else $error("free node count above pool size");

   a_alloc_has_node: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_WR && !at_leaf) |-> free_cnt_ff != '0)
      else $error("node allocated from empty pool");

   a_start_walks: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> state_ff == S_WALK_RD)
      else $error("accepted operation did not start walk");

   a_root_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM_FILL && lvl_ff == '0) |-> !free_we)
      else $error("root node pushed to free pool");

endmodule

// ===== hdl/radix_trie_index_map_top.sv =====
// channel   | dir | handshake          | payload
// req_chan  | in  | valid/ready        | mode, key, value
// rsp_chan  | out | valid/ready        | status, found_value, entry_count
//
// one operation walks the trie level by level (a read state and an evaluate state per level walked,
// one node memory read each), then a decide state, then per level allocated or freed a read and a
// write state or a slot and a fill state, then a finish state, bound by the single node memory port
// after reset the node memory is swept to zero, req not ready
// one operation at a time; a pending response blocks the next transfer on req_chan
module radix_trie_index_map_top #(
   parameter int NODE_COUNT   = 64,
   parameter int INNER_LEVELS = 7,
   parameter int VALUE_BITS   = 32
) (
   input logic         clock,
   input logic         reset,
   rtim_req_if.sink    req_chan,
   rtim_rsp_if.source  rsp_chan
);
   import rtim_pkg::*;

   logic    eng_ready;
   logic    eng_done;
   logic    start;
   req_type start_data;
   rsp_type eng_result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign req_chan.ready = eng_ready && !rsp_valid_ff;
   assign start          = req_chan.valid && req_chan.ready;

   always_comb begin
      start_data.mode  = req_chan.mode;
      start_data.key   = req_chan.key;
      start_data.value = req_chan.value;
   end

   rtim_engine #(
      .NODE_COUNT   (NODE_COUNT),
      .INNER_LEVELS (INNER_LEVELS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_data (start_data),
      .ready      (eng_ready),
      .done       (eng_done),
      .result     (eng_result)
   );

   // response holding register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.found_value = rsp_data_ff.found_value;
   assign rsp_chan.entry_count = rsp_data_ff.entry_count;

endmodule
